### design/qgi_pkg.sv
// ----------------------------------------------------------------------------
// qgi_pkg
// Shared constants, types and the control store of the gyro integrator.
// ----------------------------------------------------------------------------
package qgi_pkg;

    localparam int QUAT_FRAC_BITS = 30;
    localparam int RATE_FRAC_BITS = 24;

    localparam int DW        = 32;
    localparam int NQ        = 4;
    localparam int NG        = 3;
    localparam int CFG_IDX_W = 3;

    localparam int ACC_W_R = 66 - RATE_FRAC_BITS;
    localparam int ACC_W_Q = 67 - QUAT_FRAC_BITS;
    localparam int ACC_W   = (ACC_W_R > ACC_W_Q) ? ACC_W_R : ACC_W_Q;
    localparam int WB_W    = ACC_W + 2;
    localparam int MUL_W   = DW + 1;
    localparam int PROD_W  = 2 * MUL_W;

    localparam int PROG_LEN = 35;
    localparam int PC_W     = $clog2(PROG_LEN);

    typedef logic signed [DW-1:0] t_word;
    typedef t_word t_quat [NQ];
    typedef t_word t_vec3 [NG];

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_W    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_Z    = 3'd4;

    localparam logic [DW-1:0] HALF_STEP_RST = 32'd10737418;
    localparam t_word         QUAT_ONE      = t_word'(DW'(1) << QUAT_FRAC_BITS);
    localparam logic signed [ACC_W-1:0] HALF_ONE =
        $signed(ACC_W'(1) << (QUAT_FRAC_BITS - 1));

    // component / axis indexes
    localparam logic [1:0] IW = 2'd0;
    localparam logic [1:0] IX = 2'd1;
    localparam logic [1:0] IY = 2'd2;
    localparam logic [1:0] IZ = 2'd3;
    localparam logic [1:0] GX = 2'd0;
    localparam logic [1:0] GY = 2'd1;
    localparam logic [1:0] GZ = 2'd2;

    // multiplier operand A
    localparam logic [1:0] A_Q  = 2'd0;
    localparam logic [1:0] A_NQ = 2'd1;
    localparam logic [1:0] A_LO = 2'd2;
    localparam logic [1:0] A_HI = 2'd3;
    // multiplier operand B
    localparam logic [1:0] B_GYRO = 2'd0;
    localparam logic [1:0] B_HALF = 2'd1;
    localparam logic [1:0] B_NQ   = 2'd2;
    // product shift
    localparam logic [1:0] SH_RF = 2'd0;
    localparam logic [1:0] SH_QF = 2'd1;
    localparam logic [1:0] SH_32 = 2'd2;
    localparam logic [1:0] SH_0  = 2'd3;
    // accumulator
    localparam logic [2:0] ACC_HOLD  = 3'd0;
    localparam logic [2:0] ACC_LOAD  = 3'd1;
    localparam logic [2:0] ACC_LOADN = 3'd2;
    localparam logic [2:0] ACC_ADD   = 3'd3;
    localparam logic [2:0] ACC_SUB   = 3'd4;
    localparam logic       S_PROD    = 1'b0;
    localparam logic       S_HALF    = 1'b1;
    // writeback
    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_NQ   = 2'd1;
    localparam logic [1:0] WR_GRAV = 2'd2;
    // sequencing
    localparam logic [1:0] JMP_NEXT     = 2'd0;
    localparam logic [1:0] JMP_WAIT_IN  = 2'd1;
    localparam logic [1:0] JMP_WAIT_OUT = 2'd2;

    typedef struct packed {
        logic [1:0]      a_src;
        logic [1:0]      a_idx;
        logic [1:0]      b_src;
        logic [1:0]      b_idx;
        logic [1:0]      sh;
        logic [2:0]      acc_op;
        logic            acc_src;
        logic [1:0]      wr;
        logic [1:0]      wr_idx;
        logic            wr_addq;
        logic            wr_dbl;
        logic [1:0]      jmp;
        logic [PC_W-1:0] tgt;
    } t_uop;

    typedef struct packed {
        t_uop uop;
        logic accept;
        logic commit;
    } t_ctrl;

    function automatic t_uop mk(
        input logic [1:0] a_src,
        input logic [1:0] a_idx,
        input logic [1:0] b_src,
        input logic [1:0] b_idx,
        input logic [1:0] sh,
        input logic [2:0] acc_op,
        input logic       acc_src,
        input logic [1:0] wr,
        input logic [1:0] wr_idx,
        input logic       wr_addq,
        input logic       wr_dbl,
        input logic [1:0] jmp
    );
        t_uop u;
        u.a_src   = a_src;
        u.a_idx   = a_idx;
        u.b_src   = b_src;
        u.b_idx   = b_idx;
        u.sh      = sh;
        u.acc_op  = acc_op;
        u.acc_src = acc_src;
        u.wr      = wr;
        u.wr_idx  = wr_idx;
        u.wr_addq = wr_addq;
        u.wr_dbl  = wr_dbl;
        u.jmp     = jmp;
        u.tgt     = '0;
        return u;
    endfunction

    // Products are issued one step and consumed by the accumulator the next.
    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            // w: -x*gx - y*gy - z*gz
            6'd1:  u = mk(A_Q, IX, B_GYRO, GX, SH_RF, ACC_HOLD,  S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            6'd2:  u = mk(A_Q, IY, B_GYRO, GY, SH_RF, ACC_LOADN, S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            6'd3:  u = mk(A_Q, IZ, B_GYRO, GZ, SH_RF, ACC_SUB,   S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            6'd4:  u = mk(A_Q, IW, B_GYRO, GX, SH_RF, ACC_SUB,   S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            6'd5:  u = mk(A_LO, IW, B_HALF, GX, SH_RF, ACC_HOLD, S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            6'd6:  u = mk(A_HI, IW, B_HALF, GX, SH_32, ACC_LOAD, S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            // x: w*gx - z*gy + y*gz
            6'd7:  u = mk(A_Q, IW, B_GYRO, GX, SH_0,  ACC_ADD,   S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            6'd8:  u = mk(A_Q, IZ, B_GYRO, GY, SH_RF, ACC_LOAD,  S_PROD,
                          WR_NQ,   IW, 1'b1, 1'b0, JMP_NEXT);
            6'd9:  u = mk(A_Q, IY, B_GYRO, GZ, SH_RF, ACC_SUB,   S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            6'd10: u = mk(A_Q, IW, B_GYRO, GX, SH_RF, ACC_ADD,   S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            6'd11: u = mk(A_LO, IW, B_HALF, GX, SH_RF, ACC_HOLD, S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            6'd12: u = mk(A_HI, IW, B_HALF, GX, SH_32, ACC_LOAD, S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            // y: z*gx + w*gy - x*gz
            6'd13: u = mk(A_Q, IZ, B_GYRO, GX, SH_0,  ACC_ADD,   S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            6'd14: u = mk(A_Q, IW, B_GYRO, GY, SH_RF, ACC_LOAD,  S_PROD,
                          WR_NQ,   IX, 1'b1, 1'b0, JMP_NEXT);
            6'd15: u = mk(A_Q, IX, B_GYRO, GZ, SH_RF, ACC_ADD,   S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            6'd16: u = mk(A_Q, IW, B_GYRO, GX, SH_RF, ACC_SUB,   S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            6'd17: u = mk(A_LO, IW, B_HALF, GX, SH_RF, ACC_HOLD, S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            6'd18: u = mk(A_HI, IW, B_HALF, GX, SH_32, ACC_LOAD, S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            // z: -y*gx + x*gy + w*gz
            6'd19: u = mk(A_Q, IY, B_GYRO, GX, SH_0,  ACC_ADD,   S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            6'd20: u = mk(A_Q, IX, B_GYRO, GY, SH_RF, ACC_LOADN, S_PROD,
                          WR_NQ,   IY, 1'b1, 1'b0, JMP_NEXT);
            6'd21: u = mk(A_Q, IW, B_GYRO, GZ, SH_RF, ACC_ADD,   S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            6'd22: u = mk(A_Q, IW, B_GYRO, GX, SH_RF, ACC_ADD,   S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            6'd23: u = mk(A_LO, IW, B_HALF, GX, SH_RF, ACC_HOLD, S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            6'd24: u = mk(A_HI, IW, B_HALF, GX, SH_32, ACC_LOAD, S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            6'd25: u = mk(A_Q, IW, B_GYRO, GX, SH_0,  ACC_ADD,   S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            // gravity z: 2 * (1/2 - x*x - y*y)
            6'd26: u = mk(A_NQ, IX, B_NQ, IX, SH_QF, ACC_LOAD, S_HALF,
                          WR_NQ,   IZ, 1'b1, 1'b0, JMP_NEXT);
            6'd27: u = mk(A_NQ, IY, B_NQ, IY, SH_QF, ACC_SUB,  S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            6'd28: u = mk(A_NQ, IX, B_NQ, IZ, SH_QF, ACC_SUB,  S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            // gravity x: 2 * (x*z - w*y)
            6'd29: u = mk(A_NQ, IW, B_NQ, IY, SH_QF, ACC_LOAD, S_PROD,
                          WR_GRAV, GZ, 1'b0, 1'b1, JMP_NEXT);
            6'd30: u = mk(A_NQ, IW, B_NQ, IX, SH_QF, ACC_SUB,  S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            // gravity y: 2 * (w*x + y*z)
            6'd31: u = mk(A_NQ, IY, B_NQ, IZ, SH_QF, ACC_LOAD, S_PROD,
                          WR_GRAV, GX, 1'b0, 1'b1, JMP_NEXT);
            6'd32: u = mk(A_NQ, IW, B_NQ, IW, SH_QF, ACC_ADD,  S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_NEXT);
            6'd33: u = mk(A_NQ, IW, B_NQ, IW, SH_QF, ACC_HOLD, S_PROD,
                          WR_GRAV, GY, 1'b0, 1'b1, JMP_NEXT);
            6'd34: u = mk(A_NQ, IW, B_NQ, IW, SH_QF, ACC_HOLD, S_PROD,
                          WR_NONE, IW, 1'b0, 1'b0, JMP_WAIT_OUT);
            default: u = mk(A_Q, IW, B_GYRO, GX, SH_RF, ACC_HOLD, S_PROD,
                            WR_NONE, IW, 1'b0, 1'b0, JMP_WAIT_IN);
        endcase
        return u;
    endfunction

endpackage

### design/qgi_if.sv
// ----------------------------------------------------------------------------
// qgi_if
// Channel interfaces: gyro input, attitude output and register write.
// ----------------------------------------------------------------------------
interface qgi_in_if;
    import qgi_pkg::*;

    logic  valid;
    logic  ready;
    t_word gyro_x;
    t_word gyro_y;
    t_word gyro_z;
    logic  restart;

    modport source (output valid, gyro_x, gyro_y, gyro_z, restart, input ready);
    modport sink   (input valid, gyro_x, gyro_y, gyro_z, restart, output ready);
endinterface

interface qgi_out_if;
    import qgi_pkg::*;

    logic  valid;
    logic  ready;
    t_word att_w;
    t_word att_x;
    t_word att_y;
    t_word att_z;
    t_word grav_x;
    t_word grav_y;
    t_word grav_z;

    modport source (output valid, att_w, att_x, att_y, att_z,
                    grav_x, grav_y, grav_z, input ready);
    modport sink   (input valid, att_w, att_x, att_y, att_z,
                    grav_x, grav_y, grav_z, output ready);
endinterface

interface qgi_cfg_if;
    import qgi_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DW-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/qgi_seq.sv
// ----------------------------------------------------------------------------
// qgi_seq
// Step counter and control store; issues one control word per cycle.
// ----------------------------------------------------------------------------
module qgi_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_free,
    output logic           o_in_ready,
    output qgi_pkg::t_ctrl o_ctrl
);
    import qgi_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uop            uop;
    logic            accept;
    logic            commit;

    assign uop    = uop_rom(r_pc);
    assign accept = (uop.jmp == JMP_WAIT_IN) && i_in_valid;
    assign commit = (uop.jmp == JMP_WAIT_OUT) && i_out_free;

    always_comb begin
        case (uop.jmp)
            JMP_NEXT:     n_pc = r_pc + PC_W'(1);
            JMP_WAIT_IN:  n_pc = accept ? r_pc + PC_W'(1) : r_pc;
            JMP_WAIT_OUT: n_pc = commit ? uop.tgt : r_pc;
            default:      n_pc = r_pc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_in_ready    = (uop.jmp == JMP_WAIT_IN);
    assign o_ctrl.uop    = uop;
    assign o_ctrl.accept = accept;
    assign o_ctrl.commit = commit;

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc < PC_W'(PROG_LEN))
        else $error("step counter past end of program");

    a_commit_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (r_pc == '0))
        else $error("sequencer did not return to idle after commit");
endmodule

### design/qgi_dp.sv
// ----------------------------------------------------------------------------
// qgi_dp
// Shared multiplier, accumulator and saturating quaternion/gravity writeback.
// ----------------------------------------------------------------------------
module qgi_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  qgi_pkg::t_ctrl           i_ctrl,
    input  qgi_pkg::t_vec3           i_gyro,
    input  logic                     i_restart,
    input  logic [qgi_pkg::DW-1:0]   i_half,
    input  qgi_pkg::t_quat           i_init,
    output qgi_pkg::t_quat           o_nq,
    output qgi_pkg::t_vec3           o_grav
);
    import qgi_pkg::*;

    t_quat                     r_q;
    t_quat                     r_nq;
    t_vec3                     r_grav;
    t_vec3                     r_gyro;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   n_acc;
    logic signed [PROD_W-1:0]  r_prod;

    t_uop                      u;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    t_word                     gyro_sel;
    logic [5:0]                sh_amt;
    logic signed [PROD_W-1:0]  prod_sh;
    logic signed [ACC_W-1:0]   acc_in;
    logic signed [WB_W-1:0]    wb_q;
    logic signed [WB_W-1:0]    wb_sum;
    logic signed [WB_W-1:0]    wb_val;
    t_word                     wb_sat;

    assign u = i_ctrl.uop;

    always_comb begin
        case (u.b_idx)
            GY:      gyro_sel = r_gyro[1];
            GZ:      gyro_sel = r_gyro[2];
            default: gyro_sel = r_gyro[0];
        endcase
    end

    always_comb begin
        case (u.a_src)
            A_Q:     mul_a = MUL_W'(r_q[u.a_idx]);
            A_NQ:    mul_a = MUL_W'(r_nq[u.a_idx]);
            A_LO:    mul_a = $signed({1'b0, r_acc[DW-1:0]});
            default: mul_a = $signed({{(MUL_W - ACC_W + DW){r_acc[ACC_W-1]}},
                                      r_acc[ACC_W-1:DW]});
        endcase
        case (u.b_src)
            B_GYRO:  mul_b = MUL_W'(gyro_sel);
            B_HALF:  mul_b = $signed({1'b0, i_half});
            default: mul_b = MUL_W'(r_nq[u.b_idx]);
        endcase
    end

    always_comb begin
        case (u.sh)
            SH_RF:   sh_amt = 6'(RATE_FRAC_BITS);
            SH_QF:   sh_amt = 6'(QUAT_FRAC_BITS);
            SH_32:   sh_amt = 6'(DW);
            default: sh_amt = 6'd0;
        endcase
        prod_sh = r_prod >>> sh_amt;
        acc_in  = (u.acc_src == S_HALF) ? HALF_ONE : $signed(prod_sh[ACC_W-1:0]);
        case (u.acc_op)
            ACC_LOAD:  n_acc = acc_in;
            ACC_LOADN: n_acc = -acc_in;
            ACC_ADD:   n_acc = r_acc + acc_in;
            ACC_SUB:   n_acc = r_acc - acc_in;
            default:   n_acc = r_acc;
        endcase
    end

    // writeback: optional old component add, optional doubling, saturate
    always_comb begin
        wb_q   = u.wr_addq ? WB_W'(r_q[u.wr_idx]) : '0;
        wb_sum = WB_W'(r_acc) + wb_q;
        wb_val = u.wr_dbl ? (wb_sum <<< 1) : wb_sum;
        if ((wb_val[WB_W-1:DW-1] == '0) || (wb_val[WB_W-1:DW-1] == '1)) begin
            wb_sat = wb_val[DW-1:0];
        end else if (wb_val[WB_W-1]) begin
            wb_sat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            wb_sat = {1'b0, {(DW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        r_acc  <= n_acc;
        if (i_ctrl.accept) begin
            r_gyro <= i_gyro;
        end
        if (u.wr == WR_NQ) begin
            r_nq[u.wr_idx] <= wb_sat;
        end
        if (u.wr == WR_GRAV) begin
            case (u.wr_idx)
                GY:      r_grav[1] <= wb_sat;
                GZ:      r_grav[2] <= wb_sat;
                default: r_grav[0] <= wb_sat;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q[0] <= QUAT_ONE;
            r_q[1] <= '0;
            r_q[2] <= '0;
            r_q[3] <= '0;
        end else if (i_ctrl.accept && i_restart) begin
            r_q <= i_init;
        end else if (i_ctrl.commit) begin
            r_q <= r_nq;
        end
    end

    assign o_nq   = r_nq;
    assign o_grav = r_grav;

    a_restart_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.accept && i_restart) |=> (r_q[0] == $past(i_init[0])))
        else $error("restart did not reload the initial quaternion");
endmodule

### design/quaternion_gyro_integrator.sv
// ----------------------------------------------------------------------------
// quaternion_gyro_integrator
// First-order quaternion integration of gyro beats with gravity vector out.
// ----------------------------------------------------------------------------
// The result is registered at commit, after the input beat has been taken.
// The 35-word control program time-shares one 33x33 multiplier, so a new
// beat is taken only after the last commits; commit waits while output stalls.
// Reset: quaternion to (1, 0, 0, 0), registers to defaults, output empty.
module quaternion_gyro_integrator (
    input  logic             i_clk,
    input  logic             i_rst_n,
    qgi_in_if.sink           i_in,
    qgi_out_if.source        o_out,
    qgi_cfg_if.sink          i_cfg
);
    import qgi_pkg::*;

    logic [DW-1:0] r_half;
    t_quat         r_init;
    t_quat         r_att;
    t_vec3         r_grav;
    logic          r_out_valid;

    t_ctrl         ctrl;
    t_vec3         gyro;
    t_quat         nq;
    t_vec3         grav;
    logic          out_free;

    assign out_free = !r_out_valid || o_out.ready;
    assign gyro[0]  = i_in.gyro_x;
    assign gyro[1]  = i_in.gyro_y;
    assign gyro[2]  = i_in.gyro_z;

    qgi_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_free (out_free),
        .o_in_ready (i_in.ready),
        .o_ctrl     (ctrl)
    );

    qgi_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl),
        .i_gyro    (gyro),
        .i_restart (i_in.restart),
        .i_half    (r_half),
        .i_init    (r_init),
        .o_nq      (nq),
        .o_grav    (grav)
    );

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half    <= HALF_STEP_RST;
            r_init[0] <= QUAT_ONE;
            r_init[1] <= '0;
            r_init[2] <= '0;
            r_init[3] <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_HALF_STEP: r_half    <= i_cfg.data;
                CFG_INIT_W:    r_init[0] <= i_cfg.data;
                CFG_INIT_X:    r_init[1] <= i_cfg.data;
                CFG_INIT_Y:    r_init[2] <= i_cfg.data;
                CFG_INIT_Z:    r_init[3] <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.commit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.commit) begin
            r_att  <= nq;
            r_grav <= grav;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.att_w  = r_att[0];
    assign o_out.att_x  = r_att[1];
    assign o_out.att_y  = r_att[2];
    assign o_out.att_z  = r_att[3];
    assign o_out.grav_x = r_grav[0];
    assign o_out.grav_y = r_grav[1];
    assign o_out.grav_z = r_grav[2];

    a_commit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.commit |-> (!r_out_valid || o_out.ready))
        else $error("result committed over an untaken output beat");

    a_accept_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.accept |=> (!ctrl.commit && !i_in.ready))
        else $error("sequencer left the integration program too early");
endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for quaternion_gyro_integrator. Drives gyro beats and register
// writes, predicts every attitude/gravity beat with an independent fixed-point
// model, and compares each output beat field by field, in order.
// ----------------------------------------------------------------------------
module tb;
    import qgi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CYCLE_LIMIT = 200000;
    localparam t_word  WORD_TOP    = 32'sh7FFF_FFFF;
    localparam t_word  WORD_BOTTOM = 32'sh8000_0000;
    localparam longint SAT_HI      = 64'sd2147483647;
    localparam longint SAT_LO      = -64'sd2147483648;

    typedef logic [6:0][DW-1:0] t_att_beat;

    logic i_clk;
    logic i_rst_n;

    qgi_in_if  in_ch ();
    qgi_out_if out_ch ();
    qgi_cfg_if cfg_ch ();

    quaternion_gyro_integrator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    logic [DW-1:0] step_half = HALF_STEP_RST;
    t_word         att_init  [NQ] = '{QUAT_ONE, '0, '0, '0};
    t_word         att_state [NQ] = '{QUAT_ONE, '0, '0, '0};

    t_att_beat pending_attitude [$];
    string     beat_field [7] = '{"att_w", "att_x", "att_y", "att_z",
                                  "grav_x", "grav_y", "grav_z"};
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    int        hold_cycles    = 0;
    bit        tx_gaps        = 1'b1;
    bit        rx_gaps        = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Fixed-point prediction
    // ------------------------------------------------------------------
    function automatic t_word clamp_word(input longint v);
        if (v > SAT_HI) return WORD_TOP;
        if (v < SAT_LO) return WORD_BOTTOM;
        return t_word'(v);
    endfunction

    function automatic longint rate_term(input longint q, input longint g);
        return (q * g) >>> RATE_FRAC_BITS;
    endfunction

    function automatic longint frac_mul(input longint a, input longint b);
        return (a * b) >>> QUAT_FRAC_BITS;
    endfunction

    function automatic longint scale_by_half_step(input longint s);
        logic signed [95:0] wide_s;
        logic signed [95:0] wide_h;
        logic signed [95:0] prod;
        wide_s = s;
        wide_h = {64'd0, step_half};
        prod   = wide_s * wide_h;
        return longint'(prod >>> 32);
    endfunction

    function automatic t_att_beat integrate_sample(input t_word gx, input t_word gy,
                                                   input t_word gz, input logic restart);
        longint w, x, y, z, rx, ry, rz;
        longint dw, dx, dy, dz;
        if (restart) att_state = att_init;
        w  = att_state[IW];
        x  = att_state[IX];
        y  = att_state[IY];
        z  = att_state[IZ];
        rx = gx;
        ry = gy;
        rz = gz;
        dw = -rate_term(x, rx) - rate_term(y, ry) - rate_term(z, rz);
        dx =  rate_term(w, rx) - rate_term(z, ry) + rate_term(y, rz);
        dy =  rate_term(z, rx) + rate_term(w, ry) - rate_term(x, rz);
        dz = -rate_term(y, rx) + rate_term(x, ry) + rate_term(w, rz);
        att_state[IW] = clamp_word(w + scale_by_half_step(dw));
        att_state[IX] = clamp_word(x + scale_by_half_step(dx));
        att_state[IY] = clamp_word(y + scale_by_half_step(dy));
        att_state[IZ] = clamp_word(z + scale_by_half_step(dz));
        w = att_state[IW];
        x = att_state[IX];
        y = att_state[IY];
        z = att_state[IZ];
        return {clamp_word((longint'(1) <<< QUAT_FRAC_BITS)
                           - 2 * (frac_mul(x, x) + frac_mul(y, y))),
                clamp_word(2 * (frac_mul(w, x) + frac_mul(y, z))),
                clamp_word(2 * (frac_mul(x, z) - frac_mul(w, y))),
                att_state[IZ], att_state[IY], att_state[IX], att_state[IW]};
    endfunction

    // ------------------------------------------------------------------
    // Beat monitor: output check, register writes, input prediction
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_att_beat got;
        t_att_beat want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.grav_z, out_ch.grav_y, out_ch.grav_x,
                       out_ch.att_z, out_ch.att_y, out_ch.att_x, out_ch.att_w};
                if (pending_attitude.size() == 0) begin
                    flag_mismatch($sformatf("output beat with nothing pending, att_w=%h",
                                            got[0]));
                end else begin
                    want = pending_attitude.pop_front();
                    for (int k = 0; k < 7; k++)
                        if (got[k] !== want[k])
                            flag_mismatch($sformatf("%s got %h want %h",
                                                    beat_field[k], got[k], want[k]));
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_HALF_STEP: step_half     = cfg_ch.data;
                    CFG_INIT_W:    att_init[IW] = cfg_ch.data;
                    CFG_INIT_X:    att_init[IX] = cfg_ch.data;
                    CFG_INIT_Y:    att_init[IY] = cfg_ch.data;
                    CFG_INIT_Z:    att_init[IZ] = cfg_ch.data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                pending_attitude.push_back(integrate_sample(in_ch.gyro_x, in_ch.gyro_y,
                                                            in_ch.gyro_z, in_ch.restart));
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[%0t] timeout after %0d cycles", $realtime, cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= !(rx_gaps && $urandom_range(99) < 31);
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_sample(input t_word gx, input t_word gy, input t_word gz,
                               input logic restart);
        while (tx_gaps && $urandom_range(99) < 31) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.gyro_x  <= gx;
        in_ch.gyro_y  <= gy;
        in_ch.gyro_z  <= gz;
        in_ch.restart <= restart;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random(input bit force_restart);
        t_word r [3];
        bit    wild;
        wild = $urandom_range(99) < 20;
        for (int k = 0; k < 3; k++)
            r[k] = wild ? t_word'($urandom)
                        : t_word'($urandom) >>> $urandom_range(2, 14);
        send_sample(r[0], r[1], r[2], force_restart || $urandom_range(99) < 3);
    endtask

    task automatic settle();
        in_ch.valid  <= 1'b0;
        cfg_ch.valid <= 1'b0;
        while (pending_attitude.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_config(input logic [DW-1:0] hs, input t_word w, input t_word x,
                               input t_word y, input t_word z);
        settle();
        write_reg(CFG_HALF_STEP, hs);
        write_reg(CFG_INIT_W, w);
        write_reg(CFG_INIT_X, x);
        write_reg(CFG_INIT_Y, y);
        write_reg(CFG_INIT_Z, z);
        settle();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        send_sample('0, '0, '0, 1'b0);
        send_sample(32'sd16777216, -32'sd8388608, 32'sd4194304, 1'b0);
        send_sample(-32'sd1, 32'sd1, '0, 1'b0);
    endtask

    task automatic test_rate_extremes();
        send_sample(WORD_TOP, WORD_TOP, WORD_TOP, 1'b0);
        send_sample(WORD_BOTTOM, WORD_BOTTOM, WORD_BOTTOM, 1'b0);
        send_sample(WORD_TOP, WORD_BOTTOM, '0, 1'b1);
        send_sample(-32'sd1, 32'sd1, WORD_BOTTOM, 1'b0);
        send_sample('0, '0, WORD_TOP, 1'b1);
    endtask

    task automatic test_saturation();
        // full step with max rates drives components to the rails
        load_config('1, QUAT_ONE, '0, '0, '0);
        send_sample(WORD_TOP, WORD_TOP, WORD_TOP, 1'b1);
        send_sample(WORD_BOTTOM, WORD_TOP, WORD_BOTTOM, 1'b0);
        // oversized init quaternion saturates the gravity terms
        load_config(32'd0, WORD_TOP, WORD_TOP, WORD_TOP, WORD_TOP);
        send_sample('0, '0, '0, 1'b1);
        load_config(32'd0, WORD_BOTTOM, WORD_TOP, WORD_BOTTOM, WORD_TOP);
        send_sample(WORD_TOP, WORD_BOTTOM, WORD_TOP, 1'b1);
        send_sample(-32'sd1, -32'sd1, -32'sd1, 1'b0);
    endtask

    task automatic test_zero_init();
        load_config(32'd2147484, '0, '0, '0, '0);
        send_sample(32'sd16777216, 32'sd33554432, -32'sd50331648, 1'b1);
        send_sample(WORD_TOP, WORD_BOTTOM, WORD_TOP, 1'b0);
        send_sample(32'sd123456, -32'sd654321, 32'sd1, 1'b0);
    endtask

    task automatic test_unmapped_index();
        settle();
        for (int k = int'(CFG_INIT_Z) + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), $urandom);
        settle();
        send_sample(32'sd16777216, '0, '0, 1'b1);
        send_sample('0, -32'sd16777216, '0, 1'b0);
    endtask

    task automatic test_random_flight();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: load_config(32'd0, QUAT_ONE, '0, '0, '0);
                1: load_config('1, QUAT_ONE >>> 1, QUAT_ONE >>> 1,
                               -(QUAT_ONE >>> 1), QUAT_ONE >>> 1);
                default: begin
                    if ($urandom_range(3) == 0)
                        load_config($urandom, $urandom, $urandom, $urandom, $urandom);
                    else
                        load_config($urandom_range(0, 1 << 24),
                                    QUAT_ONE - t_word'($urandom_range(0, 1 << 26)),
                                    t_word'($urandom) >>> 3, t_word'($urandom) >>> 3,
                                    t_word'($urandom) >>> 3);
                end
            endcase
            send_random(1'b1);
            repeat (59) send_random(1'b0);
        end
    endtask

    task automatic test_steady_stream();
        settle();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        repeat (40) send_random(1'b0);
        settle();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    task automatic test_output_backpressure();
        hold_cycles = 400;
        repeat (12) send_random(1'b0);
        settle();
    endtask

    task automatic test_drain_pause();
        repeat (10) send_random(1'b0);
        settle();
        repeat (10) send_random(1'b0);
        settle();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.gyro_x   = '0;
        in_ch.gyro_y   = '0;
        in_ch.gyro_z   = '0;
        in_ch.restart  = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_rate_extremes();
        test_saturation();
        test_zero_init();
        test_unmapped_index();
        test_random_flight();
        test_steady_stream();
        test_output_backpressure();
        test_drain_pause();

        settle();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
